/* rtl/radio_pll_tuning_words_defines.svh */
// Assertion helpers shared by the RTL.
`ifndef RADIO_PLL_TUNING_WORDS_DEFINES_SVH
`define RADIO_PLL_TUNING_WORDS_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define RPLL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define RPLL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/rpll_pkg.sv */
package rpll_pkg;

   localparam int unsigned FREQ_W  = 30;
   localparam int unsigned SHIFT_W = 16;
   localparam int unsigned POWER_W = 8;
   localparam int unsigned BAND_W  = 3;
   localparam int unsigned INT_W   = 8;
   localparam int unsigned FRAC_W  = 20;
   localparam int unsigned STEP_W  = 16;
   localparam int unsigned DEV_W   = 14;
   localparam int unsigned PA_W    = 7;

   localparam int unsigned DIV_W    = 5;
   localparam int unsigned SCALED_W = 35;  // freq * divider
   localparam int unsigned X_W      = 21;  // shift * divider
   localparam int unsigned PFD_W    = 26;
   localparam int unsigned Q_BITS   = 9;   // freq / f_pfd stays below 512
   localparam int unsigned FLOW_BITS = 19; // fraction bits below the 2^19 place
   localparam int unsigned STEPS    = Q_BITS + FLOW_BITS;
   localparam int unsigned STEPS_PER_STAGE = 4;
   localparam int unsigned DIV_STAGES = STEPS / STEPS_PER_STAGE;

   localparam logic [PFD_W-1:0] PFD_NUM = 26'd60000000;

   localparam logic [FREQ_W-1:0] TH_DIV6  = 30'd705000000;
   localparam logic [FREQ_W-1:0] TH_DIV8  = 30'd525000000;
   localparam logic [FREQ_W-1:0] TH_DIV12 = 30'd353000000;
   localparam logic [FREQ_W-1:0] TH_DIV16 = 30'd239000000;
   localparam logic [FREQ_W-1:0] TH_DIV24 = 30'd177000000;

   localparam logic [BAND_W-1:0] BAND_DIV4  = 3'd0;
   localparam logic [BAND_W-1:0] BAND_DIV6  = 3'd1;
   localparam logic [BAND_W-1:0] BAND_DIV8  = 3'd2;
   localparam logic [BAND_W-1:0] BAND_DIV12 = 3'd3;
   localparam logic [BAND_W-1:0] BAND_DIV16 = 3'd4;
   localparam logic [BAND_W-1:0] BAND_DIV24 = 3'd5;

   typedef struct packed {
      logic [BAND_W-1:0]    band;
      logic [PA_W-1:0]      pa;
      logic [DEV_W-1:0]     devfix;
      logic                 shift_zero;
      logic [SCALED_W-1:0]  rem;
      logic [Q_BITS-1:0]    q;
      logic [FLOW_BITS-1:0] facc;
      logic [PFD_W-1:0]     xrem;
      logic [FLOW_BITS-1:0] xacc;
   } rpll_stage_type;

   // fixed 1300 Hz deviation word: floor(2^20 * div * 1300 / 60e6)
   function automatic logic [DEV_W-1:0] dev_fixed(input logic [BAND_W-1:0] band);
      logic [DEV_W-1:0] dev;
      unique case (band)
         BAND_DIV4:  dev = 14'd90;
         BAND_DIV6:  dev = 14'd136;
         BAND_DIV8:  dev = 14'd181;
         BAND_DIV12: dev = 14'd272;
         BAND_DIV16: dev = 14'd363;
         BAND_DIV24: dev = 14'd545;
         default:    dev = 14'd90;
      endcase
      return dev;
   endfunction

endpackage

/* rtl/rpll_channels.sv */
interface rpll_req_if import rpll_pkg::*;;
   logic                valid;
   logic                ready;
   logic [FREQ_W-1:0]   frequency_hz;
   logic [SHIFT_W-1:0]  shift_hz;
   logic signed [POWER_W-1:0] power_dbm;

   modport source(output valid, frequency_hz, shift_hz, power_dbm, input ready);
   modport sink(input valid, frequency_hz, shift_hz, power_dbm, output ready);
endinterface

interface rpll_rsp_if import rpll_pkg::*;;
   logic               valid;
   logic               ready;
   logic [BAND_W-1:0]  band_code;
   logic [INT_W-1:0]   pll_integer;
   logic [FRAC_W-1:0]  pll_fraction;
   logic [STEP_W-1:0]  channel_step;
   logic [DEV_W-1:0]   deviation_word;
   logic [PA_W-1:0]    pa_level;

   modport source(output valid, band_code, pll_integer, pll_fraction, channel_step,
                  deviation_word, pa_level, input ready);
   modport sink(input valid, band_code, pll_integer, pll_fraction, channel_step,
                deviation_word, pa_level, output ready);
endinterface

/* rtl/radio_pll_tuning_words.sv */
// An accepted request word passes the front register, the seven divider
// stages and the output register. Throughput: one word per cycle when unstalled;
// each stage holds one word and advances independently under backpressure.
// Reset: synchronous, active high, clears every stage valid bit; no
// clearing pass, the block is ready the cycle after reset drops.
`include "radio_pll_tuning_words_defines.svh"

module radio_pll_tuning_words import rpll_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rpll_req_if.sink    req_chan,
   rpll_rsp_if.source  rsp_chan
);

   // stage chain: index 0 is the front register, DIV_STAGES the last divider stage
   logic           stg_valid [DIV_STAGES+1];
   logic           stg_ready [DIV_STAGES+1];
   rpll_stage_type stg_data  [DIV_STAGES+1];

   // front: band select, freq*div, shift*div, PA map
   rpll_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .down_valid (stg_valid[0]),
      .down_ready (stg_ready[0]),
      .down_data  (stg_data[0])
   );

   // 28 restoring steps, four per stage
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      rpll_div_stage #(
         .STEP_BASE (g * STEPS_PER_STAGE)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (stg_valid[g]),
         .up_ready   (stg_ready[g]),
         .up_data    (stg_data[g]),
         .down_valid (stg_valid[g+1]),
         .down_ready (stg_ready[g+1]),
         .down_data  (stg_data[g+1])
      );
   end

   // output register: formats the words
   logic                out_valid_ff;
   logic [BAND_W-1:0]   band_ff;
   logic [INT_W-1:0]    int_ff,  int_in;
   logic [FRAC_W-1:0]   frac_ff, frac_in;
   logic [STEP_W-1:0]   step_ff;
   logic [DEV_W-1:0]    dev_ff,  dev_in;
   logic [PA_W-1:0]     pa_ff;
   logic                last_ready;
   rpll_stage_type      last;

   assign last = stg_data[DIV_STAGES];

   always_comb begin
      // integer word is q-1, held at zero below one f_pfd; q != 0 puts
      // one extra f_pfd in the remainder, i.e. the 2^19 bit of the fraction
      int_in  = (last.q == '0) ? '0 : INT_W'(last.q - Q_BITS'(1));
      frac_in = {(last.q != '0), last.facc};
      dev_in  = last.shift_zero ? last.devfix : last.xacc[DEV_W:1];
   end

   assign last_ready            = !out_valid_ff || rsp_chan.ready;
   assign stg_ready[DIV_STAGES] = last_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (last_ready) begin
         out_valid_ff <= stg_valid[DIV_STAGES];
      end
      if (last_ready && stg_valid[DIV_STAGES]) begin
         band_ff <= last.band;
         int_ff  <= int_in;
         frac_ff <= frac_in;
         step_ff <= last.xacc[STEP_W-1:0];
         dev_ff  <= dev_in;
         pa_ff   <= last.pa;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.band_code      = band_ff;
   assign rsp_chan.pll_integer    = int_ff;
   assign rsp_chan.pll_fraction   = frac_ff;
   assign rsp_chan.channel_step   = step_ff;
   assign rsp_chan.deviation_word = dev_ff;
   assign rsp_chan.pa_level       = pa_ff;

   `RPLL_ASSERT_NOW(a_front_empty_ready, !stg_valid[0], req_chan.ready, "front empty but stalled")
   `RPLL_ASSERT_NEXT(a_accept_fills, req_chan.valid && req_chan.ready, stg_valid[0], "word lost at front")
   `RPLL_ASSERT_NOW(a_frac_msb, rsp_chan.valid && (rsp_chan.pll_integer != '0), rsp_chan.pll_fraction[FRAC_W-1], "fraction msb clear")

endmodule

/* rtl/rpll_front.sv */
module rpll_front import rpll_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   rpll_req_if.sink       req_chan,
   output logic           down_valid,
   input  logic           down_ready,
   output rpll_stage_type down_data
);

   logic           valid_ff;
   rpll_stage_type data_ff;
   rpll_stage_type data_in;
   logic           up_ready;

   logic [BAND_W-1:0]   band;
   logic [DIV_W-1:0]    div;
   logic signed [11:0]  dw;
   logic [9:0]          num;
   logic [7:0]          recip;
   logic [3:0]          rsh;
   logic [17:0]         prod;
   logic [PA_W-1:0]     pa;

   always_comb begin
      band = BAND_DIV4;
      div  = 5'd4;
      if (req_chan.frequency_hz < TH_DIV6)  begin band = BAND_DIV6;  div = 5'd6;  end
      if (req_chan.frequency_hz < TH_DIV8)  begin band = BAND_DIV8;  div = 5'd8;  end
      if (req_chan.frequency_hz < TH_DIV12) begin band = BAND_DIV12; div = 5'd12; end
      if (req_chan.frequency_hz < TH_DIV16) begin band = BAND_DIV16; div = 5'd16; end
      if (req_chan.frequency_hz < TH_DIV24) begin band = BAND_DIV24; div = 5'd24; end
   end

   // PA map; the divides by 15, 3 and 5 are reciprocal multiplies (exact over each segment)
   always_comb begin
      dw    = 12'(req_chan.power_dbm);
      num   = '0;
      recip = 8'd1;
      rsh   = 4'd0;
      pa    = '0;
      if (dw < -12'sd35) begin
         pa = '0;
      end else if (dw < -12'sd7) begin
         num = 10'(dw * 12'sd2 + 12'sd74);  recip = 8'd137; rsh = 4'd11;
      end else if (dw < 12'sd2) begin
         num = 10'(dw * 12'sd2 + 12'sd26);  recip = 8'd171; rsh = 4'd9;
      end else if (dw < 12'sd8) begin
         num = 10'(dw * 12'sd5 + 12'sd20);  recip = 8'd171; rsh = 4'd9;
      end else if (dw < 12'sd13) begin
         num = 10'(dw * 12'sd3 - 12'sd4);   recip = 8'd1;   rsh = 4'd0;
      end else if (dw < 12'sd18) begin
         num = 10'(dw * 12'sd92 - 12'sd1021); recip = 8'd205; rsh = 4'd10;
      end else begin
         pa = 7'd127;
      end
      prod = 18'(num) * 18'(recip);
      if (dw >= -12'sd35 && dw < 12'sd18) begin
         pa = PA_W'(prod >> rsh);
      end
   end

   always_comb begin
      data_in            = '0;
      data_in.band       = band;
      data_in.pa         = pa;
      data_in.devfix     = dev_fixed(band);
      data_in.shift_zero = (req_chan.shift_hz == '0);
      data_in.rem        = SCALED_W'(req_chan.frequency_hz) * SCALED_W'(div);
      data_in.xrem       = PFD_W'(X_W'(req_chan.shift_hz) * X_W'(div));
   end

   assign up_ready       = !valid_ff || down_ready;
   assign req_chan.ready = up_ready;
   assign down_valid     = valid_ff;
   assign down_data      = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= req_chan.valid;
      end
      if (up_ready && req_chan.valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* rtl/rpll_div_stage.sv */
module rpll_div_stage import rpll_pkg::*; #(
   parameter int unsigned STEP_BASE = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           up_valid,
   output logic           up_ready,
   input  rpll_stage_type up_data,
   output logic           down_valid,
   input  logic           down_ready,
   output rpll_stage_type down_data
);

   logic           valid_ff;
   rpll_stage_type data_ff;
   rpll_stage_type work;

   // restoring division steps: quotient bits first, then the fraction bits;
   // the channel-step quotient runs alongside over the first steps
   always_comb begin
      int unsigned j;
      int unsigned sh;
      logic [SCALED_W-1:0] cmp;
      logic [SCALED_W-1:0] r2;
      logic [PFD_W:0]      x2;
      work = up_data;
      for (int unsigned i = 0; i < STEPS_PER_STAGE; i++) begin
         j  = STEP_BASE + i;
         sh = 0;
         cmp = '0;
         r2  = '0;
         x2  = '0;
         if (j < Q_BITS) begin
            sh  = Q_BITS - 1 - j;
            cmp = SCALED_W'(PFD_NUM) << sh;
            if (work.rem >= cmp) begin
               work.rem = work.rem - cmp;
               work.q   = work.q | (Q_BITS'(1) << sh);
            end
         end else if (j < STEPS) begin
            sh = STEPS - 1 - j;
            r2 = {work.rem[SCALED_W-2:0], 1'b0};
            if (r2 >= SCALED_W'(PFD_NUM)) begin
               r2        = r2 - SCALED_W'(PFD_NUM);
               work.facc = work.facc | (FLOW_BITS'(1) << sh);
            end
            work.rem = r2;
         end
         if (j < FLOW_BITS) begin
            sh = FLOW_BITS - 1 - j;
            x2 = {work.xrem, 1'b0};
            if (x2 >= (PFD_W+1)'(PFD_NUM)) begin
               x2        = x2 - (PFD_W+1)'(PFD_NUM);
               work.xacc = work.xacc | (FLOW_BITS'(1) << sh);
            end
            work.xrem = x2[PFD_W-1:0];
         end
      end
   end

   assign up_ready   = !valid_ff || down_ready;
   assign down_valid = valid_ff;
   assign down_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         data_ff <= work;
      end
   end

endmodule
